FILE: rtl/nrtp_pkg.sv
// ----------------------------------------------------------------------------
// nrtp_pkg
// Shared types and constants of the nested region time profiler.
// ----------------------------------------------------------------------------
package nrtp_pkg;

    localparam int CALL_BITS   = 32;
    localparam int MISUSE_BITS = 16;
    localparam int USAGE_BITS  = 14;
    localparam int RATE_BITS   = 32;
    localparam int SCALE_BITS  = 30;

    localparam logic [USAGE_BITS-1:0]  USAGE_SCALE = 14'd10000;
    localparam logic [SCALE_BITS-1:0]  RATE_SCALE  = 30'd1000000000;
    localparam logic [MISUSE_BITS-1:0] MISUSE_MAX  = '1;
    localparam logic [CALL_BITS-1:0]   CALL_MAX    = '1;
    localparam logic [RATE_BITS-1:0]   RATE_MAX    = '1;

    typedef enum logic [1:0] {
        KIND_START = 2'd0,
        KIND_END   = 2'd1,
        KIND_RESET = 2'd2,
        KIND_QUERY = 2'd3
    } t_kind;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

FILE: rtl/nrtp_in_if.sv
// ----------------------------------------------------------------------------
// nrtp_in_if
// Event channel: kind, region and timestamp with valid/ready.
// ----------------------------------------------------------------------------
interface nrtp_in_if #(
    parameter int TIME_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic [1:0]           kind;
    logic [3:0]           region;
    logic [TIME_BITS-1:0] now;

    modport source (output valid, kind, region, now, input ready);
    modport sink   (input valid, kind, region, now, output ready);
endinterface

FILE: rtl/nrtp_out_if.sv
// ----------------------------------------------------------------------------
// nrtp_out_if
// Query result channel with valid/ready.
// ----------------------------------------------------------------------------
interface nrtp_out_if #(
    parameter int TIME_BITS = 48
);
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] total_time;
    logic [31:0]          calls;
    logic [TIME_BITS-1:0] window_time;
    logic [13:0]          usage_hundredths;
    logic [TIME_BITS-1:0] avg_time;
    logic [31:0]          call_rate_millihertz;
    logic [15:0]          misuse_starts;
    logic [15:0]          misuse_ends;

    modport source (output valid, total_time, calls, window_time, usage_hundredths,
                    avg_time, call_rate_millihertz, misuse_starts, misuse_ends,
                    input ready);
    modport sink   (input valid, total_time, calls, window_time, usage_hundredths,
                    avg_time, call_rate_millihertz, misuse_starts, misuse_ends,
                    output ready);
endinterface

FILE: rtl/nested_region_time_profiler.sv
// ----------------------------------------------------------------------------
// nested_region_time_profiler
// Nested exclusive-time profiler: region table in a synchronous memory,
// read-modify-write per event, shared serial divider for query metrics.
//
//   channel  dir  payload                                     word accepted
//   i_in     in   kind, region, now                           valid & ready
//   o_out    out  totals, window, usage, mean, rate, misuse    valid & ready
//
// Start and end events pass through accept, a table read-modify-write and, when
// a paused or parent region needs updating, one more read-modify-write of it;
// reset takes accept and one read-modify-write. A query runs the bit-serial
// divider, DW = max(TIME_BITS+14,62) bits wide, for usage, rate and mean; with no
// calls the mean run is skipped, and with a zero window the divider is not run.
// The output register lets the next event enter while a result waits.
// Reset needs no clearing pass: valid bits per table entry clear at once.
// ----------------------------------------------------------------------------
module nested_region_time_profiler #(
    parameter int REGIONS   = 16,
    parameter int TIME_BITS = 48
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    nrtp_in_if.sink     i_in,
    nrtp_out_if.source  o_out
);
    localparam int AW  = $clog2(REGIONS);
    localparam int PW  = $clog2(REGIONS + 1);
    localparam int DW  = (TIME_BITS + nrtp_pkg::USAGE_BITS > 62) ?
                         TIME_BITS + nrtp_pkg::USAGE_BITS : 62;
    localparam int DVW = (TIME_BITS > nrtp_pkg::CALL_BITS) ? TIME_BITS : nrtp_pkg::CALL_BITS;
    localparam logic [PW-1:0] NONE = PW'(REGIONS);

    typedef struct packed {
        logic                             running;
        logic                             paused;
        logic [PW-1:0]                    parent;
        logic [TIME_BITS-1:0]             cst;
        logic [TIME_BITS-1:0]             acc;
        logic [nrtp_pkg::CALL_BITS-1:0]   calls;
        logic [TIME_BITS-1:0]             wstart;
        logic [nrtp_pkg::MISUSE_BITS-1:0] mstart;
        logic [nrtp_pkg::MISUSE_BITS-1:0] mend;
    } t_entry;

    localparam t_entry ENTRY_INIT = '{running: 1'b0, paused: 1'b0, parent: NONE,
                                      cst: '0, acc: '0, calls: '0, wstart: '0,
                                      mstart: '0, mend: '0};

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_READ     = 8'b0000_0010,
        S_OTHER    = 8'b0000_0100,
        S_DIV_USE  = 8'b0000_1000,
        S_DIV_RATE = 8'b0001_0000,
        S_DIV_MEAN = 8'b0010_0000,
        S_OUT      = 8'b0100_0000,
        S_HOLD     = 8'b1000_0000
    } t_state;

    t_state                    r_state;
    nrtp_pkg::t_kind           r_kind;
    logic [AW-1:0]             r_idx;
    logic [AW-1:0]             r_other;
    logic [TIME_BITS-1:0]      r_now;
    logic [PW-1:0]             r_active;

    logic [TIME_BITS-1:0]             r_q_total;
    logic [nrtp_pkg::CALL_BITS-1:0]   r_q_calls;
    logic [TIME_BITS-1:0]             r_q_win;
    logic [nrtp_pkg::USAGE_BITS-1:0]  r_q_usage;
    logic [TIME_BITS-1:0]             r_q_mean;
    logic [nrtp_pkg::RATE_BITS-1:0]   r_q_rate;
    logic [nrtp_pkg::MISUSE_BITS-1:0] r_q_ms;
    logic [nrtp_pkg::MISUSE_BITS-1:0] r_q_me;

    logic                             r_o_valid;
    logic [TIME_BITS-1:0]             r_o_total;
    logic [nrtp_pkg::CALL_BITS-1:0]   r_o_calls;
    logic [TIME_BITS-1:0]             r_o_win;
    logic [nrtp_pkg::USAGE_BITS-1:0]  r_o_usage;
    logic [TIME_BITS-1:0]             r_o_mean;
    logic [nrtp_pkg::RATE_BITS-1:0]   r_o_rate;
    logic [nrtp_pkg::MISUSE_BITS-1:0] r_o_ms;
    logic [nrtp_pkg::MISUSE_BITS-1:0] r_o_me;

    logic          in_accept;
    logic          in_range;
    logic [AW-1:0] rd_addr;
    logic [$bits(t_entry)-1:0] rd_bits;
    t_entry        rd;
    logic          wr_en;
    t_entry        wr_data;
    logic [AW-1:0] wr_addr;
    logic [TIME_BITS-1:0] win;
    logic [TIME_BITS-1:0] elapsed;

    logic          div_start;
    logic [DW-1:0] div_dividend;
    logic [DVW-1:0] div_divisor;
    logic [DW-1:0] div_q;
    nrtp_pkg::t_div_stat div_stat;

    assign in_accept = i_in.valid && i_in.ready;
    assign in_range  = 32'(i_in.region) < REGIONS;
    assign i_in.ready = (r_state == S_IDLE);
    assign rd        = t_entry'(rd_bits);
    assign win       = r_now - rd.wstart;
    assign elapsed   = r_now - rd.cst;

    // Table read address: the event's region on accept, else the region to pause/resume.
    always_comb begin
        rd_addr = AW'(i_in.region);
        if (r_state == S_READ) begin
            if (r_kind == nrtp_pkg::KIND_START) begin
                rd_addr = AW'(r_active);
            end else begin
                rd_addr = AW'(rd.parent);
            end
        end
    end

    always_comb begin
        wr_en   = 1'b0;
        wr_addr = r_idx;
        wr_data = rd;
        case (r_state)
            S_READ: begin
                wr_en = (r_kind != nrtp_pkg::KIND_QUERY);
                case (r_kind)
                    nrtp_pkg::KIND_START: begin
                        if (rd.running) begin
                            if (rd.mstart != nrtp_pkg::MISUSE_MAX) begin
                                wr_data.mstart = rd.mstart + 1'b1;
                            end
                        end else begin
                            wr_data.parent  = r_active;
                            wr_data.running = 1'b1;
                            wr_data.paused  = 1'b0;
                            wr_data.cst     = r_now;
                            if (rd.wstart == '0) begin
                                wr_data.wstart = r_now;
                            end
                        end
                    end
                    nrtp_pkg::KIND_END: begin
                        if (!rd.running) begin
                            if (rd.mend != nrtp_pkg::MISUSE_MAX) begin
                                wr_data.mend = rd.mend + 1'b1;
                            end
                        end else begin
                            if (!rd.paused) begin
                                wr_data.acc = rd.acc + elapsed;
                            end
                            if (rd.calls != nrtp_pkg::CALL_MAX) begin
                                wr_data.calls = rd.calls + 1'b1;
                            end
                            wr_data.running = 1'b0;
                        end
                    end
                    nrtp_pkg::KIND_RESET: begin
                        wr_data.acc    = '0;
                        wr_data.wstart = r_now;
                        wr_data.calls  = '0;
                    end
                    default: ;
                endcase
            end
            S_OTHER: begin
                wr_addr = r_other;
                if (r_kind == nrtp_pkg::KIND_START) begin
                    // pause the previous active region
                    wr_en = rd.running && !rd.paused;
                    wr_data.acc    = rd.acc + elapsed;
                    wr_data.paused = 1'b1;
                end else begin
                    // resume the parent
                    wr_en = rd.running && rd.paused;
                    wr_data.cst    = r_now;
                    wr_data.paused = 1'b0;
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        div_start    = 1'b0;
        div_dividend = DW'(r_q_total) * DW'(nrtp_pkg::USAGE_SCALE);
        div_divisor  = DVW'(r_q_win);
        case (r_state)
            S_READ: begin
                div_start    = (r_kind == nrtp_pkg::KIND_QUERY) && (win != '0);
                div_dividend = DW'(rd.acc) * DW'(nrtp_pkg::USAGE_SCALE);
                div_divisor  = DVW'(win);
            end
            S_DIV_USE: begin
                div_start    = div_stat.done;
                div_dividend = DW'(r_q_calls) * DW'(nrtp_pkg::RATE_SCALE);
            end
            S_DIV_RATE: begin
                div_start    = div_stat.done && (r_q_calls != '0);
                div_dividend = DW'(r_q_total);
                div_divisor  = DVW'(r_q_calls);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_active <= NONE;
        end else begin
            case (r_state)
                S_IDLE: begin
                    if (in_accept && in_range) begin
                        r_state <= S_READ;
                    end
                end
                S_READ: begin
                    r_state <= S_IDLE;
                    case (r_kind)
                        nrtp_pkg::KIND_START: begin
                            if (!rd.running) begin
                                r_active <= PW'(r_idx);
                                if (r_active < NONE && AW'(r_active) != r_idx) begin
                                    r_state <= S_OTHER;
                                end
                            end
                        end
                        nrtp_pkg::KIND_END: begin
                            if (rd.running) begin
                                r_active <= rd.parent;
                                if (rd.parent < NONE && AW'(rd.parent) != r_idx) begin
                                    r_state <= S_OTHER;
                                end
                            end
                        end
                        nrtp_pkg::KIND_QUERY: begin
                            r_state <= (win != '0) ? S_DIV_USE : S_OUT;
                        end
                        default: ;
                    endcase
                end
                S_OTHER: r_state <= S_IDLE;
                S_DIV_USE: begin
                    if (div_stat.done) begin
                        r_state <= S_DIV_RATE;
                    end
                end
                S_DIV_RATE: begin
                    if (div_stat.done) begin
                        r_state <= (r_q_calls != '0) ? S_DIV_MEAN : S_OUT;
                    end
                end
                S_DIV_MEAN: begin
                    if (div_stat.done) begin
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (!r_o_valid || o_out.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE) begin
            r_kind <= nrtp_pkg::t_kind'(i_in.kind);
            r_idx  <= AW'(i_in.region);
            r_now  <= i_in.now;
        end
        if (r_state == S_READ) begin
            r_other   <= (r_kind == nrtp_pkg::KIND_START) ? AW'(r_active) : AW'(rd.parent);
            r_q_total <= rd.acc;
            r_q_calls <= rd.calls;
            r_q_win   <= win;
            r_q_ms    <= rd.mstart;
            r_q_me    <= rd.mend;
            r_q_usage <= '0;
            r_q_rate  <= '0;
            r_q_mean  <= '0;
        end
        if (div_stat.done) begin
            case (r_state)
                S_DIV_USE: r_q_usage <= (div_q > DW'(nrtp_pkg::USAGE_SCALE)) ?
                                        nrtp_pkg::USAGE_SCALE : div_q[nrtp_pkg::USAGE_BITS-1:0];
                S_DIV_RATE: r_q_rate <= (div_q > DW'(nrtp_pkg::RATE_MAX)) ?
                                        nrtp_pkg::RATE_MAX : div_q[nrtp_pkg::RATE_BITS-1:0];
                S_DIV_MEAN: r_q_mean <= div_q[TIME_BITS-1:0];
                default: ;
            endcase
        end
    end

    // Output register: load when the slot is free or being drained.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (r_state == S_OUT && (!r_o_valid || o_out.ready)) begin
            r_o_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_o_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && (!r_o_valid || o_out.ready)) begin
            r_o_total <= r_q_total;
            r_o_calls <= r_q_calls;
            r_o_win   <= r_q_win;
            r_o_usage <= r_q_usage;
            r_o_mean  <= r_q_mean;
            r_o_rate  <= r_q_rate;
            r_o_ms    <= r_q_ms;
            r_o_me    <= r_q_me;
        end
    end

    assign o_out.valid                = r_o_valid;
    assign o_out.total_time           = r_o_total;
    assign o_out.calls                = r_o_calls;
    assign o_out.window_time          = r_o_win;
    assign o_out.usage_hundredths     = r_o_usage;
    assign o_out.avg_time             = r_o_mean;
    assign o_out.call_rate_millihertz = r_o_rate;
    assign o_out.misuse_starts        = r_o_ms;
    assign o_out.misuse_ends          = r_o_me;

    nrtp_mem #(
        .DEPTH (REGIONS),
        .AW    (AW),
        .W     ($bits(t_entry)),
        .INIT  (ENTRY_INIT)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_addr (rd_addr),
        .o_rd_data (rd_bits),
        .i_wr_en   (wr_en),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data)
    );

    nrtp_div #(
        .DW  (DW),
        .DVW (DVW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_quotient (div_q),
        .o_stat     (div_stat)
    );

    a_other_differs: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OTHER) |-> (r_other != r_idx))
        else $error("second table access hits the event's own region");

    a_usage_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_usage <= nrtp_pkg::USAGE_SCALE))
        else $error("usage above full scale");

    a_mean_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_o_valid |-> (r_o_mean <= r_o_total))
        else $error("mean exceeds total");

    a_div_owned: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_stat.done |-> (r_state == S_DIV_USE || r_state == S_DIV_RATE ||
                           r_state == S_DIV_MEAN))
        else $error("divider finished outside a query");

    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && in_range) |=> (r_state == S_READ))
        else $error("accepted event did not start a table read");
endmodule

FILE: rtl/nrtp_mem.sv
// ----------------------------------------------------------------------------
// nrtp_mem
// Region table: one write and one registered read port, per-entry valid bits
// so that unwritten entries read as the reset entry.
// ----------------------------------------------------------------------------
module nrtp_mem #(
    parameter int             DEPTH = 16,
    parameter int             AW    = 4,
    parameter int             W     = 8,
    parameter logic [W-1:0]   INIT  = '0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [AW-1:0] i_rd_addr,
    output logic [W-1:0]  o_rd_data,
    input  logic          i_wr_en,
    input  logic [AW-1:0] i_wr_addr,
    input  logic [W-1:0]  i_wr_data
);
    logic [W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0] r_valid;
    logic [W-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        r_rd_data <= r_valid[i_rd_addr] ? r_mem[i_rd_addr] : INIT;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_wr_en) begin
            r_valid[i_wr_addr] <= 1'b1;
        end
    end

    assign o_rd_data = r_rd_data;
endmodule

FILE: rtl/nrtp_div.sv
// ----------------------------------------------------------------------------
// nrtp_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nrtp_div #(
    parameter int DW  = 62,
    parameter int DVW = 48
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_start,
    input  logic [DW-1:0]       i_dividend,
    input  logic [DVW-1:0]      i_divisor,
    output logic [DW-1:0]       o_quotient,
    output nrtp_pkg::t_div_stat o_stat
);
    localparam int CW = $clog2(DW + 1);

    logic [DVW:0]   r_rem;
    logic [DW-1:0]  r_quo;
    logic [DVW-1:0] r_dvs;
    logic [CW-1:0]  r_cnt;
    logic           r_busy;
    logic           r_done;
    logic [DVW:0]   trial;
    logic           fits;

    assign trial = {r_rem[DVW-1:0], r_quo[DW-1]};
    assign fits  = trial >= {1'b0, r_dvs};

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
            r_dvs <= i_divisor;
        end else if (r_busy) begin
            r_rem <= fits ? (trial - {1'b0, r_dvs}) : trial;
            r_quo <= {r_quo[DW-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CW'(DW);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
endmodule

FILE: verif/nested_region_time_profiler_tb.sv
// ----------------------------------------------------------------------------
// nested_region_time_profiler_tb
// Drives start, end, reset and query events into the profiler through the
// event channel, predicts each query word from a cycle-free model of the
// region table, and compares every returned word field by field.
// ----------------------------------------------------------------------------
module nested_region_time_profiler_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NREG  = 16;
    localparam int TBITS = 48;
    localparam int WATCHDOG_CYCLES = 20000;
    localparam int DRAIN_CYCLES    = 400;

    typedef logic [TBITS-1:0] t_time;

    typedef struct packed {
        t_time       total_time;
        logic [31:0] calls;
        t_time       window_time;
        logic [13:0] usage_hundredths;
        t_time       avg_time;
        logic [31:0] call_rate_millihertz;
        logic [15:0] misuse_starts;
        logic [15:0] misuse_ends;
    } t_metrics;

    class region_scoreboard;
        bit          running [NREG];
        bit          paused  [NREG];
        int          parent  [NREG];
        t_time       call_t0 [NREG];
        t_time       acc     [NREG];
        logic [31:0] ncalls  [NREG];
        t_time       win0    [NREG];
        logic [15:0] bad_st  [NREG];
        logic [15:0] bad_end [NREG];
        int          active;
        t_metrics    pending[$];
        int          errors;

        function new();
            for (int i = 0; i < NREG; i++) begin
                running[i] = 0; paused[i] = 0; parent[i] = NREG;
                call_t0[i] = '0; acc[i] = '0; ncalls[i] = '0; win0[i] = '0;
                bad_st[i] = '0; bad_end[i] = '0;
            end
            active = NREG;
            errors = 0;
        endfunction

        // floor(a*b/d) saturated at cap; d nonzero
        function logic [63:0] scaled_ratio(logic [63:0] a, logic [63:0] b,
                                           logic [63:0] d, logic [63:0] cap);
            logic [127:0] q;
            q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
            return (q > {64'd0, cap}) ? cap : q[63:0];
        endfunction

        function void note_event(nrtp_pkg::t_kind k, int r, t_time now);
            t_metrics m;
            t_time win;
            case (k)
                nrtp_pkg::KIND_START: begin
                    if (running[r]) begin
                        if (bad_st[r] != nrtp_pkg::MISUSE_MAX) bad_st[r]++;
                        return;
                    end
                    parent[r] = active;
                    if (active < NREG && running[active] && !paused[active]) begin
                        acc[active] = acc[active] + (now - call_t0[active]);
                        paused[active] = 1;
                    end
                    active = r;
                    running[r] = 1; paused[r] = 0; call_t0[r] = now;
                    if (win0[r] == '0) win0[r] = now;
                end
                nrtp_pkg::KIND_END: begin
                    if (!running[r]) begin
                        if (bad_end[r] != nrtp_pkg::MISUSE_MAX) bad_end[r]++;
                        return;
                    end
                    if (!paused[r]) acc[r] = acc[r] + (now - call_t0[r]);
                    if (ncalls[r] != nrtp_pkg::CALL_MAX) ncalls[r]++;
                    running[r] = 0;
                    active = parent[r];
                    if (active < NREG && running[active] && paused[active]) begin
                        call_t0[active] = now;
                        paused[active] = 0;
                    end
                end
                nrtp_pkg::KIND_RESET: begin
                    acc[r] = '0; win0[r] = now; ncalls[r] = '0;
                end
                default: begin
                    win = now - win0[r];
                    m.total_time = acc[r];
                    m.calls = ncalls[r];
                    m.window_time = win;
                    m.usage_hundredths = '0; m.avg_time = '0; m.call_rate_millihertz = '0;
                    if (win != '0) begin
                        m.usage_hundredths = 14'(scaled_ratio(acc[r], nrtp_pkg::USAGE_SCALE,
                                                              win, nrtp_pkg::USAGE_SCALE));
                        m.call_rate_millihertz = 32'(scaled_ratio(ncalls[r],
                                                                  nrtp_pkg::RATE_SCALE,
                                                                  win, nrtp_pkg::RATE_MAX));
                        if (ncalls[r] != 0) m.avg_time = acc[r] / ncalls[r];
                    end
                    m.misuse_starts = bad_st[r];
                    m.misuse_ends = bad_end[r];
                    pending.push_back(m);
                end
            endcase
        endfunction

        task report(string what, logic [63:0] got, logic [63:0] want);
            $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
            errors++;
        endtask

        task check_word(t_metrics got);
            t_metrics w;
            if (pending.size() == 0) begin
                $display("unexpected result word at %0t", $realtime);
                errors++;
                return;
            end
            w = pending.pop_front();
            if (got.total_time !== w.total_time)
                report("total_time", got.total_time, w.total_time);
            if (got.calls !== w.calls) report("calls", got.calls, w.calls);
            if (got.window_time !== w.window_time)
                report("window_time", got.window_time, w.window_time);
            if (got.usage_hundredths !== w.usage_hundredths)
                report("usage_hundredths", got.usage_hundredths, w.usage_hundredths);
            if (got.avg_time !== w.avg_time)
                report("avg_time", got.avg_time, w.avg_time);
            if (got.call_rate_millihertz !== w.call_rate_millihertz)
                report("call_rate", got.call_rate_millihertz, w.call_rate_millihertz);
            if (got.misuse_starts !== w.misuse_starts)
                report("misuse_starts", got.misuse_starts, w.misuse_starts);
            if (got.misuse_ends !== w.misuse_ends)
                report("misuse_ends", got.misuse_ends, w.misuse_ends);
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    nrtp_in_if  #(.TIME_BITS(TBITS)) ev_ch ();
    nrtp_out_if #(.TIME_BITS(TBITS)) res_ch ();

    nested_region_time_profiler #(.REGIONS(NREG), .TIME_BITS(TBITS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (ev_ch.sink),
        .o_out   (res_ch.source)
    );

    always #5 i_clk = ~i_clk;

    region_scoreboard sb = new();
    t_time clock_us = 48'd1000;
    int idle_cycles = 0;
    int out_hold = 0;

    function automatic int gap_len();
        int p;
        p = $urandom_range(99);
        if (p < 55) return 0;
        if (p < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 60);
    endfunction

    task automatic send_event(nrtp_pkg::t_kind k, int r, t_time now);
        int g;
        ev_ch.valid  <= 1'b1;
        ev_ch.kind   <= k;
        ev_ch.region <= 4'(r);
        ev_ch.now    <= now;
        do @(posedge i_clk); while (!ev_ch.ready);
        sb.note_event(k, r, now);
        // gap after this word; keep valid high when no gap follows
        g = gap_len();
        if (g > 0) begin
            ev_ch.valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
    endtask

    // advance the timestamp mostly by small steps
    task automatic send_at_step(nrtp_pkg::t_kind k, int r);
        int p;
        p = $urandom_range(99);
        if (p < 80)      clock_us = clock_us + $urandom_range(0, 50);
        else if (p < 97) clock_us = clock_us + $urandom_range(51, 100000);
        else             clock_us = 48'({$urandom, $urandom});
        send_event(k, r, clock_us);
    endtask

    task automatic wait_drained();
        ev_ch.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending.size() != 0);
    endtask

    // result side: ready with random stalls, sample on the edge
    always @(posedge i_clk) begin
        int g;
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            out_hold = 0;
        end else begin
            if (res_ch.valid && res_ch.ready)
                sb.check_word({res_ch.total_time, res_ch.calls, res_ch.window_time,
                               res_ch.usage_hundredths, res_ch.avg_time,
                               res_ch.call_rate_millihertz, res_ch.misuse_starts,
                               res_ch.misuse_ends});
            if (out_hold > 0) begin
                out_hold = out_hold - 1;
                res_ch.ready <= 1'b0;
            end else begin
                g = gap_len();
                if (g > 0) begin
                    out_hold = g - 1;
                    res_ch.ready <= 1'b0;
                end else begin
                    res_ch.ready <= 1'b1;
                end
            end
        end
    end

    // watchdog on cycles with no accepted word
    always @(posedge i_clk) begin
        if ((ev_ch.valid && ev_ch.ready) || (res_ch.valid && res_ch.ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_CYCLES) begin
            $display("nested_region_time_profiler_tb: done, errors");
            $finish;
        end
    end

    initial begin
        int stack[$];
        int r, p;
        ev_ch.valid = 1'b0; ev_ch.kind = nrtp_pkg::KIND_START; ev_ch.region = '0;
        ev_ch.now = '0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: fresh query, window at zero, misuse, nesting, wrap, extremes
        send_event(nrtp_pkg::KIND_QUERY, 0, 48'd0);
        send_event(nrtp_pkg::KIND_END, 15, 48'd5);
        send_event(nrtp_pkg::KIND_START, 0, 48'd0);
        send_event(nrtp_pkg::KIND_START, 0, 48'd3);
        send_event(nrtp_pkg::KIND_START, 15, 48'd10);
        send_event(nrtp_pkg::KIND_END, 0, 48'd12);
        send_event(nrtp_pkg::KIND_END, 15, 48'd40);
        send_event(nrtp_pkg::KIND_END, 0, 48'd60);
        send_event(nrtp_pkg::KIND_QUERY, 0, 48'd60);
        send_event(nrtp_pkg::KIND_QUERY, 15, 48'd10);
        send_event(nrtp_pkg::KIND_QUERY, 0, 48'd0);
        send_event(nrtp_pkg::KIND_START, 7, '1);
        send_event(nrtp_pkg::KIND_END, 7, 48'd4);
        send_event(nrtp_pkg::KIND_QUERY, 7, 48'd6);
        send_event(nrtp_pkg::KIND_RESET, 7, 48'h8000_0000_0000);
        send_event(nrtp_pkg::KIND_QUERY, 7, 48'h8000_0000_0000);
        send_event(nrtp_pkg::KIND_QUERY, 7, 48'h8000_0000_0001);
        send_event(nrtp_pkg::KIND_START, 8, 48'hAAAA_AAAA_AAAA);
        send_event(nrtp_pkg::KIND_END, 8, 48'h5555_5555_5555);
        send_event(nrtp_pkg::KIND_QUERY, 8, 48'h5555_5555_5556);
        send_event(nrtp_pkg::KIND_QUERY, 15, '1);
        wait_drained();

        // random: mostly well nested start/end pairs, some noise and queries
        clock_us = 48'd200;
        for (int n = 0; n < 1300; n++) begin
            p = $urandom_range(99);
            if (n == 650) wait_drained();
            if (p < 40 && stack.size() < 6) begin
                r = $urandom_range(NREG - 1);
                if (p < 3 || !(r inside {stack})) begin
                    if (!(r inside {stack})) stack.push_back(r);
                    send_at_step(nrtp_pkg::KIND_START, r);
                end else begin
                    send_at_step(nrtp_pkg::KIND_QUERY, r);
                end
            end else if (p < 75 && stack.size() > 0) begin
                send_at_step(nrtp_pkg::KIND_END, stack.pop_back());
            end else if (p < 80) begin
                send_at_step(nrtp_pkg::KIND_END, $urandom_range(NREG - 1));
                stack.delete();
                for (int i = 0; i < NREG; i++) if (sb.running[i]) stack.push_back(i);
            end else if (p < 84) begin
                send_at_step(nrtp_pkg::KIND_RESET, $urandom_range(NREG - 1));
            end else begin
                send_at_step(nrtp_pkg::KIND_QUERY, $urandom_range(NREG - 1));
            end
        end
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("nested_region_time_profiler_tb: done, clean");
        else
            $display("nested_region_time_profiler_tb: done, errors");
        $finish;
    end
endmodule
